@@ design/ralm_pkg.sv @@
// Shared types and constants of the rectified average level meter.
// Holds field widths, full-scale codes, level limits and register indexes.
// Depends on nothing; the top level takes names from it by scope.
`timescale 1ns / 1ps

package ralm_pkg;

  // Field and state widths.
  localparam int CHANNEL_W   = 3;
  localparam int LEVEL_W     = 14;
  localparam int OFFSET_W    = 12;
  localparam int SPP_W       = 14;
  localparam int SUM_W       = 27;
  localparam int COUNT_W     = 15;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 14;

  // Full-scale ADC codes of the two channel kinds.
  localparam logic [OFFSET_W-1:0] VOLT_FULL_CODE = 12'd4090;
  localparam logic [OFFSET_W-1:0] CURR_FULL_CODE = 12'd3797;

  // Peak values and saturation limits in milli-units.
  localparam logic [LEVEL_W-1:0] VOLT_PEAK_MILLI = 14'd10000;
  localparam logic [LEVEL_W-1:0] CURR_PEAK_MILLI = 14'd5000;
  localparam logic [LEVEL_W-1:0] VOLT_SAT_MILLI  = 14'd9990;
  localparam logic [LEVEL_W-1:0] CURR_SAT_MILLI  = 14'd5000;

  // Limits of the accumulators.
  localparam logic [SUM_W-1:0]   SUM_MAX   = '1;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Register reset values.
  localparam logic [OFFSET_W-1:0] OFFSET_VOLT_RESET = 12'd2355;
  localparam logic [OFFSET_W-1:0] OFFSET_CURR_RESET = 12'd2837;
  localparam logic [SPP_W-1:0]    SPP_RESET         = 14'd333;

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_OFFSET_VOLT_A      = 3'd0,
    REG_OFFSET_VOLT_B      = 3'd1,
    REG_OFFSET_VOLT_C      = 3'd2,
    REG_OFFSET_VOLT_D      = 3'd3,
    REG_OFFSET_CURRENT     = 3'd4,
    REG_SAMPLES_PER_PERIOD = 3'd5
  } cfg_reg_e;

  // One entry of the per-channel accumulator memory.
  typedef struct packed {
    logic [SUM_W-1:0]   sum;
    logic [COUNT_W-1:0] count;
  } entry_t;

endpackage

@@ design/rectified_average_level_meter.sv @@
// Rectified average level meter: per-channel deviation accumulator and divider.
// Depends on ralm_pkg for widths, constants, register indexes and the entry type.
//
//   Channel  Direction  Handshake                 Payload
//   in       sink       in_valid_i / in_ready_o   channel_i, sample_i
//   out      source     out_valid_o / out_ready_i out_channel_o, level_milli_o
//   cfg      sink       cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// A sample that does not close its window first reads the channel's entry from the
// accumulator memory and then updates it and writes it back.
// A request on an unknown channel is taken and leaves no trace.
// A sample that closes its window then runs the multiplies, the saturation check,
// the restoring divider and the output state; when the level saturates or the band
// is empty the divider is skipped.
// Reset clears the entry valid bits at once, so no clearing pass is needed.
// The output register lets the next request in while a result waits; the
// block stalls in its output cycle only when a second result finds it full.
`timescale 1ns / 1ps

module rectified_average_level_meter #(
  parameter int PERIODS_PER_WINDOW = 3,
  parameter int VOLT_CHANNELS      = 4,
  parameter int SAMPLE_BITS        = 12
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Sample channel.
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [ralm_pkg::CHANNEL_W-1:0]    channel_i,
  input  logic [SAMPLE_BITS-1:0]            sample_i,
  // Result channel.
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [ralm_pkg::CHANNEL_W-1:0]    out_channel_o,
  output logic [ralm_pkg::LEVEL_W-1:0]      level_milli_o,
  // Configuration write channel.
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [ralm_pkg::CFG_INDEX_W-1:0]  cfg_index_i,
  input  logic [ralm_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int NUM_CH   = VOLT_CHANNELS + 1;
  localparam int AW       = (NUM_CH > 1) ? $clog2(NUM_CH) : 1;
  localparam int XW       = (SAMPLE_BITS > ralm_pkg::OFFSET_W) ? SAMPLE_BITS
                                                              : ralm_pkg::OFFSET_W;
  localparam int WIN_W    = ralm_pkg::SPP_W + $clog2(PERIODS_PER_WINDOW + 1);
  localparam int NUM_W    = ralm_pkg::SUM_W + ralm_pkg::LEVEL_W;
  localparam int DEN_W    = ralm_pkg::OFFSET_W + ralm_pkg::COUNT_W;
  localparam int DIV_CW   = $clog2(ralm_pkg::LEVEL_W);
  localparam logic [ralm_pkg::CHANNEL_W:0] CURR_CH =
    (ralm_pkg::CHANNEL_W + 1)'(VOLT_CHANNELS);
  localparam logic [WIN_W-1:0] PERIODS_L = WIN_W'(PERIODS_PER_WINDOW);

  // State codes.
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_UPD  = 3'd1;
  localparam logic [2:0] S_MNUM = 3'd2;
  localparam logic [2:0] S_MDEN = 3'd3;
  localparam logic [2:0] S_MSAT = 3'd4;
  localparam logic [2:0] S_CHK  = 3'd5;
  localparam logic [2:0] S_DIV  = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  logic [2:0] state_q, state_d;

  // Configuration registers.
  logic [ralm_pkg::OFFSET_W-1:0] off_volt_q [4];
  logic [ralm_pkg::OFFSET_W-1:0] off_curr_q;
  logic [ralm_pkg::SPP_W-1:0]    spp_q;

  // Request registers.
  logic [ralm_pkg::CHANNEL_W-1:0] ch_q;
  logic [SAMPLE_BITS-1:0]         smp_q;

  // Accumulator memory, its read register and the entry valid bits.
  ralm_pkg::entry_t mem_q [NUM_CH];
  ralm_pkg::entry_t rd_q;
  logic [NUM_CH-1:0] vld_q;

  // Window-end operands and divider state.
  logic [ralm_pkg::SUM_W-1:0]    sum_q;
  logic [ralm_pkg::COUNT_W-1:0]  cnt_q;
  logic [ralm_pkg::OFFSET_W-1:0] range_q;
  logic                          rpos_q;
  logic                          curr_q;
  logic [NUM_W-1:0]              num_q;
  logic [DEN_W-1:0]              den_q;
  logic [NUM_W-1:0]              satden_q;
  logic [NUM_W-1:0]              rem_q;
  logic [NUM_W-1:0]              dsh_q;
  logic [ralm_pkg::LEVEL_W-1:0]  quo_q;
  logic [DIV_CW-1:0]             div_cnt_q;
  logic [ralm_pkg::LEVEL_W-1:0]  level_q;

  // Output register.
  logic                           out_valid_q;
  logic [ralm_pkg::CHANNEL_W-1:0] out_channel_q;
  logic [ralm_pkg::LEVEL_W-1:0]   out_level_q;

  logic in_acc, ch_ok, out_free;
  logic [AW-1:0] in_addr, ch_addr;

  assign in_ready_o    = (state_q == S_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign out_valid_o   = out_valid_q;
  assign out_channel_o = out_channel_q;
  assign level_milli_o = out_level_q;

  assign ch_ok    = ({1'b0, channel_i} <= CURR_CH);
  assign in_acc   = in_valid_i && in_ready_o;
  assign in_addr  = AW'(channel_i);
  assign ch_addr  = AW'(ch_q);
  assign out_free = !out_valid_q || out_ready_i;

  // Configuration writes; indexes past the list are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) begin
        off_volt_q[i] <= ralm_pkg::OFFSET_VOLT_RESET;
      end
      off_curr_q <= ralm_pkg::OFFSET_CURR_RESET;
      spp_q      <= ralm_pkg::SPP_RESET;
    end else if (cfg_valid_i) begin
      case (ralm_pkg::cfg_reg_e'(cfg_index_i))
        ralm_pkg::REG_OFFSET_VOLT_A: off_volt_q[0] <= cfg_data_i[ralm_pkg::OFFSET_W-1:0];
        ralm_pkg::REG_OFFSET_VOLT_B: off_volt_q[1] <= cfg_data_i[ralm_pkg::OFFSET_W-1:0];
        ralm_pkg::REG_OFFSET_VOLT_C: off_volt_q[2] <= cfg_data_i[ralm_pkg::OFFSET_W-1:0];
        ralm_pkg::REG_OFFSET_VOLT_D: off_volt_q[3] <= cfg_data_i[ralm_pkg::OFFSET_W-1:0];
        ralm_pkg::REG_OFFSET_CURRENT: off_curr_q <= cfg_data_i[ralm_pkg::OFFSET_W-1:0];
        ralm_pkg::REG_SAMPLES_PER_PERIOD: spp_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Offset, range and clamped deviation of the held sample.
  logic                          is_curr;
  logic [ralm_pkg::OFFSET_W-1:0] off_sel, full_sel, range_sel;
  logic                          rpos;
  logic [XW-1:0]                 smp_x, off_x, absd;
  logic [ralm_pkg::OFFSET_W-1:0] dev;

  always_comb begin
    is_curr = ({1'b0, ch_q} == CURR_CH);
    if (is_curr) begin
      off_sel  = off_curr_q;
      full_sel = ralm_pkg::CURR_FULL_CODE;
    end else begin
      off_sel  = (ch_q < 3'd4) ? off_volt_q[ch_q[1:0]] : off_volt_q[3];
      full_sel = ralm_pkg::VOLT_FULL_CODE;
    end
    rpos      = (off_sel < full_sel);
    range_sel = full_sel - off_sel;
    smp_x     = XW'(smp_q);
    off_x     = XW'(off_sel);
    absd      = (smp_x >= off_x) ? (smp_x - off_x) : (off_x - smp_x);
    // The deviation never exceeds the range: that is the clamp to the band.
    if (!rpos) begin
      dev = '0;
    end else if (absd > XW'(range_sel)) begin
      dev = range_sel;
    end else begin
      dev = absd[ralm_pkg::OFFSET_W-1:0];
    end
  end

  // Updated entry and window check.
  ralm_pkg::entry_t          cur;
  logic [ralm_pkg::SUM_W:0]  sum_wide;
  logic [ralm_pkg::SUM_W-1:0]   sum_new;
  logic [ralm_pkg::COUNT_W-1:0] cnt_new;
  logic [WIN_W-1:0]          win_full, win;
  logic                      done;

  always_comb begin
    cur      = vld_q[ch_addr] ? rd_q : '0;
    sum_wide = {1'b0, cur.sum} + (ralm_pkg::SUM_W + 1)'(dev);
    sum_new  = sum_wide[ralm_pkg::SUM_W] ? ralm_pkg::SUM_MAX
                                         : sum_wide[ralm_pkg::SUM_W-1:0];
    cnt_new  = (cur.count < ralm_pkg::COUNT_MAX) ? cur.count + 1'b1 : cur.count;
    win_full = WIN_W'(spp_q) * PERIODS_L;
    win      = (win_full > WIN_W'(ralm_pkg::COUNT_MAX)) ? WIN_W'(ralm_pkg::COUNT_MAX)
                                                        : win_full;
    done     = (WIN_W'(cnt_new) >= win);
  end

  // Accumulator memory: read at request, write back in the update cycle.
  always_ff @(posedge clk_i) begin
    if (in_acc && ch_ok) begin
      rd_q <= mem_q[in_addr];
    end
    if (state_q == S_UPD) begin
      mem_q[ch_addr] <= done ? '0 : ralm_pkg::entry_t'{sum: sum_new, count: cnt_new};
    end
  end

  // Entry valid bits; an entry not yet written reads as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (state_q == S_UPD) begin
      vld_q[ch_addr] <= 1'b1;
    end
  end

  // Sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_acc && ch_ok) state_d = S_UPD;
      S_UPD:  state_d = done ? S_MNUM : S_IDLE;
      S_MNUM: state_d = S_MDEN;
      S_MDEN: state_d = S_MSAT;
      S_MSAT: state_d = S_CHK;
      S_CHK: begin
        if (!rpos_q || (num_q >= satden_q)) begin
          state_d = S_OUT;
        end else begin
          state_d = S_DIV;
        end
      end
      S_DIV:  if (div_cnt_q == '0) state_d = S_OUT;
      S_OUT:  if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Request capture.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ch_q  <= channel_i;
      smp_q <= sample_i;
    end
  end

  // Window-end datapath: three multiplies, a saturation check, then a
  // restoring divider that makes one quotient bit a cycle.
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_UPD: begin
        sum_q   <= sum_new;
        cnt_q   <= cnt_new;
        range_q <= range_sel;
        rpos_q  <= rpos;
        curr_q  <= is_curr;
      end
      S_MNUM: begin
        num_q <= NUM_W'(sum_q) * NUM_W'(curr_q ? ralm_pkg::CURR_PEAK_MILLI
                                               : ralm_pkg::VOLT_PEAK_MILLI);
      end
      S_MDEN: begin
        den_q <= DEN_W'(range_q) * DEN_W'(cnt_q);
      end
      S_MSAT: begin
        satden_q <= NUM_W'(den_q) * NUM_W'(curr_q ? ralm_pkg::CURR_SAT_MILLI
                                                  : ralm_pkg::VOLT_SAT_MILLI);
      end
      S_CHK: begin
        rem_q     <= num_q;
        dsh_q     <= NUM_W'(den_q) << (ralm_pkg::LEVEL_W - 1);
        quo_q     <= '0;
        div_cnt_q <= DIV_CW'(ralm_pkg::LEVEL_W - 1);
        if (!rpos_q) begin
          level_q <= '0;
        end else begin
          level_q <= curr_q ? ralm_pkg::CURR_SAT_MILLI : ralm_pkg::VOLT_SAT_MILLI;
        end
      end
      S_DIV: begin
        if (rem_q >= dsh_q) begin
          rem_q <= rem_q - dsh_q;
          quo_q <= {quo_q[ralm_pkg::LEVEL_W-2:0], 1'b1};
          if (div_cnt_q == '0) level_q <= {quo_q[ralm_pkg::LEVEL_W-2:0], 1'b1};
        end else begin
          quo_q <= {quo_q[ralm_pkg::LEVEL_W-2:0], 1'b0};
          if (div_cnt_q == '0) level_q <= {quo_q[ralm_pkg::LEVEL_W-2:0], 1'b0};
        end
        dsh_q     <= dsh_q >> 1;
        div_cnt_q <= div_cnt_q - 1'b1;
      end
      default: ;
    endcase
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      if (state_q == S_OUT && out_free) out_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_OUT && out_free) begin
      out_channel_q <= ch_q;
      out_level_q   <= level_q;
    end
  end

`ifndef SYNTH
  // No result ever exceeds the voltage limit.
  a_level_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (level_milli_o <= ralm_pkg::VOLT_SAT_MILLI))
    else $error("level above voltage limit");

  // A current-channel result stays within the current limit.
  a_curr_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && ({1'b0, out_channel_o} == CURR_CH))
      |-> (level_milli_o <= ralm_pkg::CURR_SAT_MILLI))
    else $error("current level above its limit");

  // The divider remainder stays below twice the shifted divisor.
  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> ({1'b0, rem_q} < {dsh_q, 1'b0}))
    else $error("divider remainder out of range");

  // A request on a known channel is updated in the following cycle.
  a_upd_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && ch_ok) |=> (state_q == S_UPD))
    else $error("accepted request not updated");
`endif

endmodule

@@ test/tb_rectified_average_level_meter.sv @@
// Self-checking testbench of the rectified average level meter.
// Drives sample requests and register writes; each level comes from its own model or from a typed table row.
// Depends on ralm_pkg and on rectified_average_level_meter only.
`timescale 1ns / 1ps

module tb_rectified_average_level_meter;

  localparam int WINDOW_PERIODS = 3;
  localparam int VOLT_CH        = 4;
  localparam int SAMPLE_W       = 12;
  localparam int NUM_CH         = VOLT_CH + 1;
  localparam int SETTLE_CYCLES  = 32;
  localparam int DRAIN_LIMIT    = 5000;
  localparam int HOLD_CYCLES    = 300;
  localparam int PHASE_SAMPLES  = 75;
  localparam int LONG_SAMPLES   = 60;

  // Register indexes that select nothing.
  localparam logic [ralm_pkg::CFG_INDEX_W-1:0] REG_UNUSED_6 = 3'd6;
  localparam logic [ralm_pkg::CFG_INDEX_W-1:0] REG_UNUSED_7 = 3'd7;

  // One completed window as it leaves the block.
  typedef struct packed {
    logic [ralm_pkg::CHANNEL_W-1:0] chan;
    logic [ralm_pkg::LEVEL_W-1:0]   level;
  } level_rec_t;

  // One row of the directed table: a register write or a sample request.
  typedef struct packed {
    logic                             is_write;
    logic [ralm_pkg::CFG_INDEX_W-1:0] sel;
    logic [ralm_pkg::CFG_DATA_W-1:0]  val;
    logic                             typed;
    logic [ralm_pkg::LEVEL_W-1:0]     level;
  } step_row_t;

  localparam logic ROW_WRITE     = 1'b1;
  localparam logic ROW_SAMPLE    = 1'b0;
  localparam logic ROW_TYPED     = 1'b1;
  localparam logic ROW_PREDICTED = 1'b0;
  localparam int   DIRECTED_ROWS = 28;

  // Directed table: sel is the register index of a write or the channel of a sample.
  localparam step_row_t DIRECTED [DIRECTED_ROWS] = '{
    // Every sample closes its window.
    '{ROW_WRITE,  ralm_pkg::REG_SAMPLES_PER_PERIOD, 14'd0,    ROW_PREDICTED, 14'd0},
    '{ROW_SAMPLE, 3'd0,                             14'd4095, ROW_TYPED,     14'd9990},
    '{ROW_SAMPLE, 3'd0,                             14'd0,    ROW_TYPED,     14'd9990},
    '{ROW_SAMPLE, 3'd0,                             14'd2355, ROW_TYPED,     14'd0},
    '{ROW_SAMPLE, 3'd4,                             14'd4095, ROW_TYPED,     14'd5000},
    '{ROW_SAMPLE, 3'd4,                             14'd0,    ROW_TYPED,     14'd5000},
    // Unknown channels give nothing.
    '{ROW_SAMPLE, 3'd5,                             14'd1234, ROW_PREDICTED, 14'd0},
    '{ROW_SAMPLE, 3'd7,                             14'd4095, ROW_PREDICTED, 14'd0},
    // Offsets at and above full scale read as zero.
    '{ROW_WRITE,  ralm_pkg::REG_OFFSET_VOLT_D,      14'd4090, ROW_PREDICTED, 14'd0},
    '{ROW_SAMPLE, 3'd3,                             14'd4095, ROW_TYPED,     14'd0},
    '{ROW_WRITE,  ralm_pkg::REG_OFFSET_CURRENT,     14'd4095, ROW_PREDICTED, 14'd0},
    '{ROW_SAMPLE, 3'd4,                             14'd100,  ROW_TYPED,     14'd0},
    // Zero offset gives the widest band.
    '{ROW_WRITE,  ralm_pkg::REG_OFFSET_VOLT_A,      14'd0,    ROW_PREDICTED, 14'd0},
    '{ROW_SAMPLE, 3'd0,                             14'd4095, ROW_TYPED,     14'd9990},
    '{ROW_SAMPLE, 3'd0,                             14'd0,    ROW_TYPED,     14'd0},
    '{ROW_SAMPLE, 3'd0,                             14'd2045, ROW_TYPED,     14'd5000},
    // A band one code wide, then a level of half the peak.
    '{ROW_WRITE,  ralm_pkg::REG_OFFSET_VOLT_B,      14'd4089, ROW_PREDICTED, 14'd0},
    '{ROW_SAMPLE, 3'd1,                             14'd4090, ROW_TYPED,     14'd9990},
    '{ROW_WRITE,  ralm_pkg::REG_OFFSET_VOLT_C,      14'd2048, ROW_PREDICTED, 14'd0},
    '{ROW_SAMPLE, 3'd2,                             14'd3069, ROW_TYPED,     14'd5000},
    // Writes to unused indexes change nothing.
    '{ROW_WRITE,  REG_UNUSED_6,                     14'd0,    ROW_PREDICTED, 14'd0},
    '{ROW_WRITE,  REG_UNUSED_7,                     14'h3FFF, ROW_PREDICTED, 14'd0},
    // Three-sample window.
    '{ROW_WRITE,  ralm_pkg::REG_SAMPLES_PER_PERIOD, 14'd1,    ROW_PREDICTED, 14'd0},
    '{ROW_SAMPLE, 3'd2,                             14'd1024, ROW_PREDICTED, 14'd0},
    '{ROW_SAMPLE, 3'd2,                             14'd2048, ROW_PREDICTED, 14'd0},
    '{ROW_SAMPLE, 3'd2,                             14'd4095, ROW_PREDICTED, 14'd0},
    '{ROW_SAMPLE, 3'd6,                             14'd0,    ROW_PREDICTED, 14'd0},
    '{ROW_SAMPLE, 3'd1,                             14'd0,    ROW_PREDICTED, 14'd0}
  };

  logic                             clk_i;
  logic                             rst_ni      = 1'b0;
  logic                             in_valid_i  = 1'b0;
  logic                             in_ready_o;
  logic [ralm_pkg::CHANNEL_W-1:0]   channel_i   = '0;
  logic [SAMPLE_W-1:0]              sample_i    = '0;
  logic                             out_valid_o;
  logic                             out_ready_i = 1'b0;
  logic [ralm_pkg::CHANNEL_W-1:0]   out_channel_o;
  logic [ralm_pkg::LEVEL_W-1:0]     level_milli_o;
  logic                             cfg_valid_i = 1'b0;
  logic                             cfg_ready_o;
  logic [ralm_pkg::CFG_INDEX_W-1:0] cfg_index_i = '0;
  logic [ralm_pkg::CFG_DATA_W-1:0]  cfg_data_i  = '0;

  // Mirror of the block's registers and accumulators.
  logic [ralm_pkg::OFFSET_W-1:0] offset_volt [4];
  logic [ralm_pkg::OFFSET_W-1:0] offset_curr;
  logic [ralm_pkg::SPP_W-1:0]    period_samples;
  int unsigned                   dev_sum   [NUM_CH];
  int unsigned                   win_count [NUM_CH];

  level_rec_t pending_levels [$];

  int idle_pct   = 0;
  int stall_pct  = 0;
  int hold_left  = 0;
  int mismatches = 0;
  int n_samples  = 0;
  int n_ignored  = 0;
  int n_levels   = 0;
  int n_writes   = 0;

  rectified_average_level_meter #(
    .PERIODS_PER_WINDOW(WINDOW_PERIODS),
    .VOLT_CHANNELS     (VOLT_CH),
    .SAMPLE_BITS       (SAMPLE_W)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .channel_i    (channel_i),
    .sample_i     (sample_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_channel_o(out_channel_o),
    .level_milli_o(level_milli_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Hard limit on the run.
  initial begin
    #(4_000_000);
    $display("TB_ERROR");
    $finish;
  end

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t ns: %s", $time, what);
    mismatches++;
  endtask

  function automatic void meter_reset();
    for (int c = 0; c < 4; c++) offset_volt[c] = ralm_pkg::OFFSET_VOLT_RESET;
    offset_curr    = ralm_pkg::OFFSET_CURR_RESET;
    period_samples = ralm_pkg::SPP_RESET;
    for (int c = 0; c < NUM_CH; c++) begin
      dev_sum[c]   = 0;
      win_count[c] = 0;
    end
  endfunction

  function automatic void meter_write(input logic [ralm_pkg::CFG_INDEX_W-1:0] idx,
                                      input logic [ralm_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      ralm_pkg::REG_OFFSET_VOLT_A, ralm_pkg::REG_OFFSET_VOLT_B,
      ralm_pkg::REG_OFFSET_VOLT_C, ralm_pkg::REG_OFFSET_VOLT_D:
        offset_volt[idx[1:0]] = data[ralm_pkg::OFFSET_W-1:0];
      ralm_pkg::REG_OFFSET_CURRENT:     offset_curr = data[ralm_pkg::OFFSET_W-1:0];
      ralm_pkg::REG_SAMPLES_PER_PERIOD: period_samples = data;
      default: ;
    endcase
  endfunction

  // Accumulates one sample; returns 1 with the level when its window closes.
  function automatic bit meter_accept(input logic [ralm_pkg::CHANNEL_W-1:0] ch,
                                      input logic [SAMPLE_W-1:0] smp,
                                      output level_rec_t rec);
    int full_code, zero_code, span, lo, v, dev;
    int unsigned win;
    longint unsigned lvl, peak, sat;
    rec = '0;
    if (ch > VOLT_CH) return 1'b0;
    if (ch == VOLT_CH) begin
      full_code = ralm_pkg::CURR_FULL_CODE;
      zero_code = offset_curr;
      peak      = ralm_pkg::CURR_PEAK_MILLI;
      sat       = ralm_pkg::CURR_SAT_MILLI;
    end else begin
      full_code = ralm_pkg::VOLT_FULL_CODE;
      // Voltage channels past the fourth share the last offset.
      zero_code = offset_volt[(ch < 4) ? ch[1:0] : 2'd3];
      peak      = ralm_pkg::VOLT_PEAK_MILLI;
      sat       = ralm_pkg::VOLT_SAT_MILLI;
    end
    span = full_code - zero_code;

    // Clamp to the band around the offset and rectify.
    dev = 0;
    if (span > 0) begin
      lo = zero_code - span;
      v  = smp;
      if (v < lo) v = lo;
      if (v > full_code) v = full_code;
      dev = (v > zero_code) ? v - zero_code : zero_code - v;
    end
    if (dev_sum[ch] + dev > ralm_pkg::SUM_MAX) dev_sum[ch] = ralm_pkg::SUM_MAX;
    else dev_sum[ch] += dev;
    if (win_count[ch] < ralm_pkg::COUNT_MAX) win_count[ch]++;

    win = period_samples * WINDOW_PERIODS;
    if (win > ralm_pkg::COUNT_MAX) win = ralm_pkg::COUNT_MAX;
    if (win_count[ch] < win) return 1'b0;

    // Window closed: average over the band, saturated per channel kind.
    lvl = 0;
    if (span > 0) begin
      lvl = (longint'(dev_sum[ch]) * peak) / (longint'(span) * longint'(win_count[ch]));
      if (lvl > sat) lvl = sat;
    end
    dev_sum[ch]   = 0;
    win_count[ch] = 0;
    rec.chan  = ch;
    rec.level = lvl[ralm_pkg::LEVEL_W-1:0];
    return 1'b1;
  endfunction

  // Offers one sample request after a random gap and records what it should produce.
  task automatic send_sample(input logic [ralm_pkg::CHANNEL_W-1:0] ch,
                             input logic [SAMPLE_W-1:0] smp,
                             input logic typed,
                             input logic [ralm_pkg::LEVEL_W-1:0] typed_level);
    int gap;
    level_rec_t rec;
    gap = 0;
    while ($urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    channel_i  <= ch;
    sample_i   <= smp;
    do @(posedge clk_i); while (!in_ready_o);
    n_samples++;
    if (ch > VOLT_CH) n_ignored++;
    if (meter_accept(ch, smp, rec)) begin
      if (typed) rec.level = typed_level;
      pending_levels.push_back(rec);
    end
  endtask

  // Writes one register and leaves the channel idle afterwards.
  task automatic write_reg(input logic [ralm_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [ralm_pkg::CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    meter_write(idx, data);
    n_writes++;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Stops offering samples, waits for every expected level, then lets the block settle.
  task automatic wait_idle();
    int waited;
    waited = 0;
    in_valid_i <= 1'b0;
    while (pending_levels.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    if (pending_levels.size() != 0) begin
      report_mismatch($sformatf("%0d expected levels never came out", pending_levels.size()));
      pending_levels.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [ralm_pkg::CFG_DATA_W-1:0] pick_offset();
    case ($urandom_range(7))
      0:       return 14'd0;
      1:       return 14'd4089;
      2:       return 14'd3796;
      3:       return 14'($urandom_range(4090, 4095));
      default: return 14'($urandom_range(1500, 3000));
    endcase
  endfunction

  // Result side: checks each accepted level and drives ready with stalls and hold-offs.
  initial begin : level_sink
    level_rec_t want;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        n_levels++;
        if (pending_levels.size() == 0) begin
          report_mismatch($sformatf("level %0d on channel %0d with no request waiting",
                                    level_milli_o, out_channel_o));
        end else begin
          want = pending_levels.pop_front();
          if (out_channel_o !== want.chan)
            report_mismatch($sformatf("channel %0d, expected %0d", out_channel_o, want.chan));
          if (level_milli_o !== want.level)
            report_mismatch($sformatf("channel %0d level %0d, expected %0d",
                                      want.chan, level_milli_o, want.level));
        end
      end
      if (hold_left > 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else begin
        out_ready_i <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Main sequence.
  initial begin : stimulus
    int i;
    int ph;
    logic [ralm_pkg::CHANNEL_W-1:0] ch;
    logic [SAMPLE_W-1:0]            smp;
    meter_reset();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table.
    for (i = 0; i < DIRECTED_ROWS; i++) begin
      if (DIRECTED[i].is_write) begin
        wait_idle();
        write_reg(DIRECTED[i].sel, DIRECTED[i].val);
      end else begin
        send_sample(DIRECTED[i].sel, DIRECTED[i].val[SAMPLE_W-1:0],
                    DIRECTED[i].typed, DIRECTED[i].level);
      end
    end

    // Back-pressure: every sample yields a level while the result side holds off.
    wait_idle();
    write_reg(ralm_pkg::REG_SAMPLES_PER_PERIOD, 14'd0);
    hold_left = HOLD_CYCLES;
    repeat (24) send_sample(3'($urandom_range(0, 4)), 12'($urandom_range(0, 4095)), 1'b0, '0);

    // Longest window, capped by the count width: a short burst gives no level.
    wait_idle();
    write_reg(ralm_pkg::REG_OFFSET_VOLT_C, 14'($urandom_range(1500, 3000)));
    write_reg(ralm_pkg::REG_SAMPLES_PER_PERIOD, 14'h3FFF);
    repeat (LONG_SAMPLES) send_sample(3'd2, 12'($urandom_range(0, 4095)), 1'b0, '0);

    // Random phases with short windows and different idling.
    for (ph = 0; ph < 6; ph++) begin
      wait_idle();
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 49; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 49; end
        default: begin idle_pct = 9; stall_pct = 9; end
      endcase
      write_reg(ralm_pkg::REG_OFFSET_VOLT_A, pick_offset());
      write_reg(ralm_pkg::REG_OFFSET_VOLT_B, pick_offset());
      write_reg(ralm_pkg::REG_OFFSET_VOLT_C, pick_offset());
      write_reg(ralm_pkg::REG_OFFSET_VOLT_D, pick_offset());
      write_reg(ralm_pkg::REG_OFFSET_CURRENT, pick_offset());
      case ($urandom_range(5))
        0:       write_reg(ralm_pkg::REG_SAMPLES_PER_PERIOD, 14'd0);
        1:       write_reg(ralm_pkg::REG_SAMPLES_PER_PERIOD, 14'd50);
        default: write_reg(ralm_pkg::REG_SAMPLES_PER_PERIOD, 14'($urandom_range(1, 4)));
      endcase
      repeat (PHASE_SAMPLES) begin
        // Mostly valid channels, a few unknown ones.
        if ($urandom_range(99) < 6) ch = 3'($urandom_range(5, 7));
        else ch = 3'($urandom_range(0, 4));
        case ($urandom_range(9))
          0:       smp = 12'd0;
          1:       smp = 12'hFFF;
          default: smp = 12'($urandom_range(0, 4095));
        endcase
        send_sample(ch, smp, 1'b0, '0);
      end
    end

    idle_pct  = 0;
    stall_pct = 0;
    wait_idle();
    $display("Run covered %0d sample requests (%0d on unknown channels), %0d levels, %0d writes.",
             n_samples, n_ignored, n_levels, n_writes);
    $display("Offsets at both ends and past full scale, short and capped windows, stalls.");
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/ralm_pkg.sv
design/rectified_average_level_meter.sv
test/tb_rectified_average_level_meter.sv
